[rtl/cpu16_pkg.sv]
// Shared types, codes and helper functions for the 16-bit CPU core step block.
package cpu16_pkg;

    localparam int RAM_WORDS_DEF = 65536;

    // Item modes
    localparam logic [1:0] MODE_WR   = 2'd0;
    localparam logic [1:0] MODE_EXEC = 2'd1;
    localparam logic [1:0] MODE_RD   = 2'd2;
    localparam logic [1:0] MODE_REG  = 2'd3;

    // Register read-back indices
    localparam logic [15:0] REG_SP = 16'd8;
    localparam logic [15:0] REG_PC = 16'd9;
    localparam logic [15:0] REG_O  = 16'd10;

    // Basic opcodes
    localparam logic [3:0] OP_NB  = 4'h0;
    localparam logic [3:0] OP_SET = 4'h1;
    localparam logic [3:0] OP_ADD = 4'h2;
    localparam logic [3:0] OP_SUB = 4'h3;
    localparam logic [3:0] OP_MUL = 4'h4;
    localparam logic [3:0] OP_DIV = 4'h5;
    localparam logic [3:0] OP_MOD = 4'h6;
    localparam logic [3:0] OP_SHL = 4'h7;
    localparam logic [3:0] OP_SHR = 4'h8;
    localparam logic [3:0] OP_AND = 4'h9;
    localparam logic [3:0] OP_BOR = 4'hA;
    localparam logic [3:0] OP_XOR = 4'hB;
    localparam logic [3:0] OP_IFE = 4'hC;
    localparam logic [3:0] OP_IFN = 4'hD;
    localparam logic [3:0] OP_IFG = 4'hE;
    localparam logic [3:0] OP_IFB = 4'hF;

    localparam logic [5:0] NB_JSR = 6'h01;

    // Operand codes
    localparam logic [5:0] CODE_POP      = 6'h18;
    localparam logic [5:0] CODE_PEEK     = 6'h19;
    localparam logic [5:0] CODE_PUSH     = 6'h1A;
    localparam logic [5:0] CODE_SP       = 6'h1B;
    localparam logic [5:0] CODE_PC       = 6'h1C;
    localparam logic [5:0] CODE_O        = 6'h1D;
    localparam logic [5:0] CODE_NEXT_MEM = 6'h1E;
    localparam logic [5:0] CODE_NEXT_LIT = 6'h1F;

    typedef enum logic [2:0] {
        K_GPR,
        K_SP,
        K_PC,
        K_O,
        K_MEM,
        K_LIT
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] addr;
        logic [15:0] val;
    } operand_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [15:0] a;
        logic [15:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] value;
        logic [15:0] ovf;
        logic        ovf_we;
        logic        cond;
    } alu_rsp_t;

    function automatic logic takes_word(input logic [5:0] code);
        return (code[5:3] == 3'b010) || (code == CODE_NEXT_MEM) || (code == CODE_NEXT_LIT);
    endfunction

    function automatic logic [1:0] instr_words(input logic [15:0] w);
        logic [1:0] n;
        n = 2'd1;
        if ((w[3:0] != OP_NB) && takes_word(w[9:4])) n = n + 2'd1;
        if (takes_word(w[15:10])) n = n + 2'd1;
        return n;
    endfunction

endpackage

[rtl/cpu16_ram.sv]
// Single-port word memory with registered read data.
module cpu16_ram #(
    parameter int DEPTH = cpu16_pkg::RAM_WORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [15:0]   wdata,
    output logic [15:0]   rdata
);
    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/cpu16_alu.sv]
// Shared arithmetic, logic, compare and shift unit with an iterative divider.
module cpu16_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cpu16_pkg::alu_req_t req,
    output cpu16_pkg::alu_rsp_t rsp
);
    import cpu16_pkg::*;

    logic        busy_reg, busy_next;
    logic        is_div_reg, is_div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] b_reg, b_next;
    alu_rsp_t    rsp_reg, rsp_next;

    logic [16:0] rem_sh;
    logic        ge;
    logic [15:0] rem_s;
    logic [31:0] dvd_s;
    logic [16:0] sum;
    logic [16:0] diff;
    logic [31:0] prod;
    logic [31:0] shl_t;
    logic [31:0] shr_t;
    logic        long_sh;

    // one restoring divide step
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[31]};
        ge     = rem_sh >= {1'b0, b_reg};
        rem_s  = ge ? 16'(rem_sh - {1'b0, b_reg}) : rem_sh[15:0];
        dvd_s  = {dvd_reg[30:0], ge};
    end

    always_comb
    begin
        sum     = {1'b0, req.a} + {1'b0, req.b};
        diff    = {1'b0, req.a} - {1'b0, req.b};
        prod    = req.a * req.b;
        long_sh = req.b[15:5] != 11'd0;
        shl_t   = {16'h0, req.a} << req.b[4:0];
        shr_t   = {req.a, 16'h0} >> req.b[4:0];
    end

    always_comb
    begin
        busy_next   = busy_reg;
        is_div_next = is_div_reg;
        cnt_next    = cnt_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        b_next      = b_reg;
        rsp_next    = rsp_reg;
        rsp_next.done = 1'b0;

        if (busy_reg)
        begin
            dvd_next = dvd_s;
            rem_next = rem_s;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next       = 1'b0;
                rsp_next.done   = 1'b1;
                rsp_next.cond   = 1'b0;
                if (is_div_reg)
                begin
                    rsp_next.value  = dvd_s[31:16];
                    rsp_next.ovf    = dvd_s[15:0];
                    rsp_next.ovf_we = 1'b1;
                end
                else
                begin
                    rsp_next.value  = rem_s;
                    rsp_next.ovf    = 16'h0;
                    rsp_next.ovf_we = 1'b0;
                end
            end
        end
        else if (start)
        begin
            rsp_next.done   = 1'b1;
            rsp_next.value  = 16'h0;
            rsp_next.ovf    = 16'h0;
            rsp_next.ovf_we = 1'b0;
            rsp_next.cond   = 1'b0;
            unique case (req.op)
                OP_SET: rsp_next.value = req.b;
                OP_ADD:
                begin
                    rsp_next.value  = sum[15:0];
                    rsp_next.ovf    = {15'h0, sum[16]};
                    rsp_next.ovf_we = 1'b1;
                end
                OP_SUB:
                begin
                    rsp_next.value  = diff[15:0];
                    rsp_next.ovf    = diff[16] ? 16'hFFFF : 16'h0;
                    rsp_next.ovf_we = 1'b1;
                end
                OP_MUL:
                begin
                    rsp_next.value  = prod[15:0];
                    rsp_next.ovf    = prod[31:16];
                    rsp_next.ovf_we = 1'b1;
                end
                OP_DIV, OP_MOD:
                begin
                    rsp_next.ovf_we = req.op == OP_DIV;
                    if (req.b != 16'h0)
                    begin
                        // hold the result back and iterate
                        rsp_next.done = 1'b0;
                        busy_next     = 1'b1;
                        is_div_next   = req.op == OP_DIV;
                        cnt_next      = (req.op == OP_DIV) ? 6'd32 : 6'd16;
                        dvd_next      = {req.a, 16'h0};
                        rem_next      = 16'h0;
                        b_next        = req.b;
                    end
                end
                OP_SHL:
                begin
                    rsp_next.value  = long_sh ? 16'h0 : shl_t[15:0];
                    rsp_next.ovf    = long_sh ? 16'h0 : shl_t[31:16];
                    rsp_next.ovf_we = 1'b1;
                end
                OP_SHR:
                begin
                    rsp_next.value  = long_sh ? 16'h0 : shr_t[31:16];
                    rsp_next.ovf    = long_sh ? 16'h0 : shr_t[15:0];
                    rsp_next.ovf_we = 1'b1;
                end
                OP_AND: rsp_next.value = req.a & req.b;
                OP_BOR: rsp_next.value = req.a | req.b;
                OP_XOR: rsp_next.value = req.a ^ req.b;
                OP_IFE: rsp_next.cond = req.a == req.b;
                OP_IFN: rsp_next.cond = req.a != req.b;
                OP_IFG: rsp_next.cond = req.a > req.b;
                OP_IFB: rsp_next.cond = (req.a & req.b) != 16'h0;
                default: rsp_next.value = 16'h0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            rsp_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rsp_reg  <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_div_reg <= is_div_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        b_reg      <= b_next;
    end

    assign rsp = rsp_reg;
endmodule

[rtl/sixteen_bit_cpu_core_step.sv]
// Top level of the 16-bit CPU core step block: sequencer, register state and memory port.
//
// Usage: drive mode, address and data and raise start; the transaction is taken at a
// rising edge where start is high and busy is low. busy stays high until the result
// has been delivered. Each transaction yields exactly one result, shown on read_data,
// program_counter, stack_pointer, overflow_word and skipped for one cycle while done
// is high; the receiver cannot stall, so it must take the result in that cycle.
// A memory write or register read goes straight to the result; a memory read waits on
// the registered read data. An instruction is fetched, its operands decoded (each operand
// word, memory operand or false conditional adds a step) and executed; DIV and MOD also
// wait for the divider. The next transaction is taken only once the block is back in idle
// after the result. The steps follow from the single memory port (one access a cycle,
// registered read) and the bit-serial divider. One transaction is in flight at a time.
// Reset clears the registers at once, then sweeps the memory to zero one word a
// cycle with busy held high; no transaction is taken meanwhile.
module sixteen_bit_cpu_core_step #(
    parameter int RAM_WORDS = cpu16_pkg::RAM_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [15:0] address,
    input  logic [15:0] data,
    output logic        done,
    output logic [15:0] read_data,
    output logic [15:0] program_counter,
    output logic [15:0] stack_pointer,
    output logic [15:0] overflow_word,
    output logic        skipped
);
    import cpu16_pkg::*;

    localparam int AW    = $clog2(RAM_WORDS);
    localparam int RED_K = $clog2((65536 + RAM_WORDS - 1) / RAM_WORDS);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_MRD   = 11'b00000000100,
        S_INSTR = 11'b00000001000,
        S_OPD   = 11'b00000010000,
        S_NEXTW = 11'b00000100000,
        S_VALW  = 11'b00001000000,
        S_EXEC  = 11'b00010000000,
        S_ALU   = 11'b00100000000,
        S_SKIP  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    // Reduce a word address modulo the memory depth by conditional subtraction.
    function automatic logic [AW-1:0] mem_index(input logic [15:0] a);
        logic [16:0] r;
        r = {1'b0, a};
        for (int k = RED_K - 1; k >= 0; k--)
        begin
            if (r >= 17'(RAM_WORDS << k)) r = r - 17'(RAM_WORDS << k);
        end
        return r[AW-1:0];
    endfunction

    state_t      state_reg, state_next;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] sp_reg, sp_next;
    logic [15:0] o_reg, o_next;
    logic [15:0] rd_reg, rd_next;
    logic        skip_reg, skip_next;
    logic [15:0] instr_reg, instr_next;
    logic        sel_a_reg, sel_a_next;
    operand_t    wop_reg, wop_next;
    operand_t    opa_reg, opa_next;
    operand_t    opb_reg, opb_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [15:0] gpr_reg [8];

    logic        gpr_we;
    logic [2:0]  gpr_widx;
    logic [15:0] gpr_wdata;
    logic [2:0]  gpr_ridx;
    logic [15:0] gpr_rdata;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_wdata;
    logic [15:0]   mem_rdata;

    logic        alu_start;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;

    logic [5:0]  code;
    logic        adv;
    operand_t    fin_op;
    logic [15:0] a_val;
    logic [15:0] b_val;
    logic [15:0] sp_dec;
    logic [15:0] idx_sum;

    cpu16_ram #(
        .DEPTH (RAM_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    cpu16_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (alu_start),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // operand field under decode: a first, then b
    assign code      = sel_a_reg ? instr_reg[9:4] : instr_reg[15:10];
    assign gpr_ridx  = (state_reg == S_IDLE) ? address[2:0] : code[2:0];
    assign gpr_rdata = gpr_reg[gpr_ridx];
    assign sp_dec    = sp_reg - 16'd1;
    assign idx_sum   = gpr_rdata + mem_rdata;

    // SP, PC and O operands are sampled only once both operands are decoded
    always_comb
    begin
        unique case (opa_reg.kind)
            K_SP:    a_val = sp_reg;
            K_PC:    a_val = pc_reg;
            K_O:     a_val = o_reg;
            default: a_val = opa_reg.val;
        endcase
        unique case (opb_reg.kind)
            K_SP:    b_val = sp_reg;
            K_PC:    b_val = pc_reg;
            K_O:     b_val = o_reg;
            default: b_val = opb_reg.val;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        o_next     = o_reg;
        rd_next    = rd_reg;
        skip_next  = skip_reg;
        instr_next = instr_reg;
        sel_a_next = sel_a_reg;
        wop_next   = wop_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        clr_next   = clr_reg;
        gpr_we     = 1'b0;
        gpr_widx   = opa_reg.addr[2:0];
        gpr_wdata  = alu_rsp.value;
        mem_we     = 1'b0;
        mem_addr   = mem_index(pc_reg);
        mem_wdata  = 16'h0;
        alu_start  = 1'b0;
        alu_req.op = instr_reg[3:0];
        alu_req.a  = a_val;
        alu_req.b  = b_val;
        adv        = 1'b0;
        fin_op     = wop_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(RAM_WORDS - 1)) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    rd_next   = 16'h0;
                    skip_next = 1'b0;
                    unique case (mode)
                        MODE_WR:
                        begin
                            mem_we     = 1'b1;
                            mem_addr   = mem_index(address);
                            mem_wdata  = data;
                            state_next = S_DONE;
                        end
                        MODE_EXEC:
                        begin
                            // fetch the instruction word
                            pc_next    = pc_reg + 16'd1;
                            state_next = S_INSTR;
                        end
                        MODE_RD:
                        begin
                            mem_addr   = mem_index(address);
                            state_next = S_MRD;
                        end
                        MODE_REG:
                        begin
                            priority if (address < 16'd8) rd_next = gpr_rdata;
                            else if (address == REG_SP) rd_next = sp_reg;
                            else if (address == REG_PC) rd_next = pc_reg;
                            else if (address == REG_O) rd_next = o_reg;
                            else rd_next = 16'h0;
                            state_next = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_MRD:
            begin
                rd_next    = mem_rdata;
                state_next = S_DONE;
            end
            S_INSTR:
            begin
                instr_next = mem_rdata;
                // non-basic opcodes decode only operand b
                sel_a_next = mem_rdata[3:0] != OP_NB;
                state_next = S_OPD;
            end
            S_OPD:
            begin
                priority if (code[5])
                begin
                    fin_op.kind = K_LIT;
                    fin_op.val  = {11'h0, code[4:0]};
                    adv         = 1'b1;
                end
                else if (code[5:3] == 3'b000)
                begin
                    fin_op.kind = K_GPR;
                    fin_op.addr = {13'h0, code[2:0]};
                    fin_op.val  = gpr_rdata;
                    adv         = 1'b1;
                end
                else if (code[5:3] == 3'b001)
                begin
                    wop_next.kind = K_MEM;
                    wop_next.addr = gpr_rdata;
                    mem_addr      = mem_index(gpr_rdata);
                    state_next    = S_VALW;
                end
                else if (takes_word(code))
                begin
                    pc_next    = pc_reg + 16'd1;
                    state_next = S_NEXTW;
                end
                else if (code == CODE_POP)
                begin
                    wop_next.kind = K_MEM;
                    wop_next.addr = sp_reg;
                    mem_addr      = mem_index(sp_reg);
                    sp_next       = sp_reg + 16'd1;
                    state_next    = S_VALW;
                end
                else if (code == CODE_PEEK)
                begin
                    wop_next.kind = K_MEM;
                    wop_next.addr = sp_reg;
                    mem_addr      = mem_index(sp_reg);
                    state_next    = S_VALW;
                end
                else if (code == CODE_PUSH)
                begin
                    wop_next.kind = K_MEM;
                    wop_next.addr = sp_dec;
                    mem_addr      = mem_index(sp_dec);
                    sp_next       = sp_dec;
                    state_next    = S_VALW;
                end
                else if (code == CODE_SP)
                begin
                    fin_op.kind = K_SP;
                    adv         = 1'b1;
                end
                else if (code == CODE_PC)
                begin
                    fin_op.kind = K_PC;
                    adv         = 1'b1;
                end
                else
                begin
                    fin_op.kind = K_O;
                    adv         = 1'b1;
                end
            end
            S_NEXTW:
            begin
                priority if (code == CODE_NEXT_LIT)
                begin
                    fin_op.kind = K_LIT;
                    fin_op.val  = mem_rdata;
                    adv         = 1'b1;
                end
                else if (code == CODE_NEXT_MEM)
                begin
                    wop_next.kind = K_MEM;
                    wop_next.addr = mem_rdata;
                    mem_addr      = mem_index(mem_rdata);
                    state_next    = S_VALW;
                end
                else
                begin
                    wop_next.kind = K_MEM;
                    wop_next.addr = idx_sum;
                    mem_addr      = mem_index(idx_sum);
                    state_next    = S_VALW;
                end
            end
            S_VALW:
            begin
                fin_op.val = mem_rdata;
                adv        = 1'b1;
            end
            S_EXEC:
            begin
                if (instr_reg[3:0] == OP_NB)
                begin
                    if (instr_reg[9:4] == NB_JSR)
                    begin
                        sp_next   = sp_dec;
                        mem_we    = 1'b1;
                        mem_addr  = mem_index(sp_dec);
                        mem_wdata = pc_reg;
                        pc_next   = b_val;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    alu_start  = 1'b1;
                    state_next = S_ALU;
                end
            end
            S_ALU:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_DONE;
                    if (instr_reg[3:2] == 2'b11)
                    begin
                        if (!alu_rsp.cond)
                        begin
                            // read the next instruction to size the skip
                            skip_next  = 1'b1;
                            state_next = S_SKIP;
                        end
                    end
                    else
                    begin
                        if (alu_rsp.ovf_we) o_next = alu_rsp.ovf;
                        // the operand write comes last so a write to O wins
                        unique case (opa_reg.kind)
                            K_GPR: gpr_we = 1'b1;
                            K_SP:  sp_next = alu_rsp.value;
                            K_PC:  pc_next = alu_rsp.value;
                            K_O:   o_next = alu_rsp.value;
                            K_MEM:
                            begin
                                mem_we    = 1'b1;
                                mem_addr  = mem_index(opa_reg.addr);
                                mem_wdata = alu_rsp.value;
                            end
                            default: gpr_we = 1'b0;
                        endcase
                    end
                end
            end
            S_SKIP:
            begin
                pc_next    = pc_reg + {14'h0, instr_words(mem_rdata)};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // store the finished operand and advance to the next one or to execute
        if (adv)
        begin
            if (sel_a_reg)
            begin
                opa_next   = fin_op;
                sel_a_next = 1'b0;
                state_next = S_OPD;
            end
            else
            begin
                opb_next   = fin_op;
                state_next = S_EXEC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pc_reg    <= 16'h0;
            sp_reg    <= 16'h0;
            o_reg     <= 16'h0;
            rd_reg    <= 16'h0;
            skip_reg  <= 1'b0;
            sel_a_reg <= 1'b0;
            clr_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                gpr_reg[i] <= 16'h0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            o_reg     <= o_next;
            rd_reg    <= rd_next;
            skip_reg  <= skip_next;
            sel_a_reg <= sel_a_next;
            clr_reg   <= clr_next;
            if (gpr_we)
            begin
                gpr_reg[gpr_widx] <= gpr_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        instr_reg <= instr_next;
        wop_reg   <= wop_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
    end

    assign busy            = state_reg != S_IDLE;
    assign done            = state_reg == S_DONE;
    assign read_data       = rd_reg;
    assign program_counter = pc_reg;
    assign stack_pointer   = sp_reg;
    assign overflow_word   = o_reg;
    assign skipped         = skip_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but block not busy");

    a_skip_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && skipped) |-> (read_data == 16'h0))
        else $error("skipped instruction carries read data");

    a_alu_start: assert property (@(posedge clk) disable iff (!rst_n)
        alu_start |=> (state_reg == S_ALU))
        else $error("arithmetic unit started outside execute");
endmodule
